@@ hw/rtl/sv39pt_pkg.sv @@
// ----------------------------------------------------------------------------
// sv39pt_pkg
// Shared types and constants of the Sv39 page-table translator.
// ----------------------------------------------------------------------------
`default_nettype none

package sv39pt_pkg;

  localparam int FUNC_W    = 1;
  localparam int INDEX_W   = 13;
  localparam int WORD_W    = 64;
  localparam int VADDR_W   = 64;
  localparam int PADDR_W   = 56;
  localparam int STATUS_W  = 3;
  localparam int ROOT_W    = 4;

  localparam int VPN_W      = 9;
  localparam int PAGE_SHIFT = 12;
  localparam int PPN_LSB    = 10;
  localparam int PPN_W      = 44;
  localparam int PTE_V_BIT  = 0;
  localparam int PTE_U_BIT  = 4;
  localparam int PAGE_WORDS = 512;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_XLATE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 3'd0,
    STATUS_LIMIT        = 3'd1,
    STATUS_MISSING      = 3'd2,
    STATUS_LEAF_INVALID = 3'd3,
    STATUS_NOT_USER     = 3'd4,
    STATUS_OUTSIDE      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_L2,
    ST_L1,
    ST_L0,
    ST_HOLD
  } walk_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sv39pt_if.sv @@
// ----------------------------------------------------------------------------
// sv39pt channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sv39pt_req_if import sv39pt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [INDEX_W-1:0]   entry_index;
  logic [WORD_W-1:0]    entry_value;
  logic [VADDR_W-1:0]   vaddr;

  modport source (output valid, func, entry_index, entry_value, vaddr, input ready);
  modport sink   (input valid, func, entry_index, entry_value, vaddr, output ready);
endinterface

interface sv39pt_rsp_if import sv39pt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [PADDR_W-1:0]   paddr;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, paddr, status, input ready);
  modport sink   (input valid, paddr, status, output ready);
endinterface

interface sv39pt_cfg_if import sv39pt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [ROOT_W-1:0]    root_page;

  modport source (output valid, root_page, input ready);
  modport sink   (input valid, root_page, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sv39pt_store.sv @@
// ----------------------------------------------------------------------------
// sv39pt_store
// Page-table word store: one write port, one registered read port, and a
// zeroing sweep over every word after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sv39pt_store import sv39pt_pkg::*; #(
  parameter int WORDS = 8192,
  parameter int AW    = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data,
  output logic              clearing
);

  logic [WORD_W-1:0] mem [WORDS];
  logic [AW-1:0]     clear_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == AW'(WORDS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + AW'(1);
      end
    end
  end

  always_comb begin
    mem_we = clearing | wr_en;
    mem_wa = clearing ? clear_addr : wr_addr;
    mem_wd = clearing ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sv39_page_table_translate.sv @@
// ----------------------------------------------------------------------------
// sv39_page_table_translate
// Sv39 three-level translator over a local store of TABLE_PAGES page-table
// pages of 512 words. A request word either writes one table entry or
// translates a virtual address: the level-2, level-1 and level-0
// entries are read one after another from the single store read port, so a
// full walk holds the input through ST_L2, ST_L1 and ST_L0 before its
// response is registered, sooner when a check fails early. Responses sit
// in an output register, so a new request is taken while the last response
// waits. After reset the store is zeroed one word a cycle over every word,
// during which no request is taken; root_page writes are accepted at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module sv39_page_table_translate import sv39pt_pkg::*; #(
  parameter int TABLE_PAGES   = 16,
  parameter int VA_LIMIT_BITS = 38
) (
  input  logic         clk,
  input  logic         rst,
  sv39pt_req_if.sink   req,
  sv39pt_rsp_if.source rsp,
  sv39pt_cfg_if.sink   cfg
);

  localparam int unsigned STORE_WORDS = TABLE_PAGES * PAGE_WORDS;
  localparam int AW = $clog2(STORE_WORDS);
  localparam int PW = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

  walk_state_t          state;
  walk_state_t          state_next;
  logic [ROOT_W-1:0]    root_page;
  logic [2*VPN_W-1:0]   vpn;

  logic                 rsp_valid;
  logic [PADDR_W-1:0]   rsp_paddr;
  status_t              rsp_status;
  logic [PADDR_W-1:0]   hold_paddr;
  status_t              hold_status;

  logic                 clearing;
  logic                 wr_en;
  logic                 rd_en;
  logic [PW-1:0]        rd_page;
  logic [VPN_W-1:0]     rd_idx;
  logic [WORD_W-1:0]    rd_data;

  logic                 fin;
  logic [PADDR_W-1:0]   fin_paddr;
  status_t              fin_status;
  logic                 out_free;
  logic                 out_load;
  logic [PADDR_W-1:0]   out_paddr;
  status_t              out_status;
  logic                 hold_en;

  logic                 req_fire;
  logic                 pte_v;
  logic                 pte_u;
  logic [PPN_W-1:0]     pte_ppn;
  logic                 ppn_in_store;
  logic                 root_in_store;
  logic                 over_limit;

  sv39pt_store #(
    .WORDS (STORE_WORDS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (AW'(req.entry_index)),
    .wr_data  (req.entry_value),
    .rd_en    (rd_en),
    .rd_addr  (AW'({rd_page, rd_idx})),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  assign req.ready  = (state == ST_IDLE) && !clearing;
  assign cfg.ready  = 1'b1;
  assign rsp.valid  = rsp_valid;
  assign rsp.paddr  = rsp_paddr;
  assign rsp.status = rsp_status;

  assign req_fire      = req.valid && req.ready;
  assign out_free      = !rsp_valid || rsp.ready;
  assign pte_v         = rd_data[PTE_V_BIT];
  assign pte_u         = rd_data[PTE_U_BIT];
  assign pte_ppn       = rd_data[PPN_LSB +: PPN_W];
  assign ppn_in_store  = pte_ppn < PPN_W'(TABLE_PAGES);
  assign root_in_store = 32'(root_page) < 32'(TABLE_PAGES);
  assign over_limit    = (req.vaddr >> VA_LIMIT_BITS) != '0;

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_page    = '0;
    rd_idx     = '0;
    fin        = 1'b0;
    fin_paddr  = '0;
    fin_status = STATUS_OK;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req.func == FUNC_WRITE) begin
            wr_en = 32'(req.entry_index) < STORE_WORDS;
            fin   = 1'b1;
          end else if (over_limit) begin
            fin        = 1'b1;
            fin_status = STATUS_LIMIT;
          end else if (!root_in_store) begin
            fin        = 1'b1;
            fin_status = STATUS_OUTSIDE;
          end else begin
            rd_en      = 1'b1;
            rd_page    = PW'(root_page);
            rd_idx     = req.vaddr[PAGE_SHIFT + 2*VPN_W +: VPN_W];
            state_next = ST_L2;
          end
        end
      end
      ST_L2, ST_L1: begin
        if (!pte_v) begin
          fin        = 1'b1;
          fin_status = STATUS_MISSING;
        end else if (!ppn_in_store) begin
          fin        = 1'b1;
          fin_status = STATUS_OUTSIDE;
        end else begin
          rd_en      = 1'b1;
          rd_page    = pte_ppn[PW-1:0];
          rd_idx     = (state == ST_L2) ? vpn[VPN_W +: VPN_W] : vpn[VPN_W-1:0];
          state_next = (state == ST_L2) ? ST_L1 : ST_L0;
        end
      end
      ST_L0: begin
        fin = 1'b1;
        if (!pte_v) begin
          fin_status = STATUS_LEAF_INVALID;
        end else if (!pte_u) begin
          fin_status = STATUS_NOT_USER;
        end else begin
          fin_paddr = {pte_ppn, PAGE_SHIFT'(0)};
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_load   = 1'b0;
    out_paddr  = fin_paddr;
    out_status = fin_status;
    hold_en    = 1'b0;
    if (state == ST_HOLD) begin
      out_load   = out_free;
      out_paddr  = hold_paddr;
      out_status = hold_status;
    end else if (fin) begin
      if (out_free) begin
        out_load   = 1'b1;
        state_next = ST_IDLE;
      end else begin
        hold_en    = 1'b1;
        state_next = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      root_page <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        root_page <= cfg.root_page;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      vpn <= req.vaddr[PAGE_SHIFT +: 2*VPN_W];
    end
    if (out_load) begin
      rsp_paddr  <= out_paddr;
      rsp_status <= out_status;
    end
    if (hold_en) begin
      hold_paddr  <= fin_paddr;
      hold_status <= fin_status;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sv39pt_checker.sv @@
// ----------------------------------------------------------------------------
// sv39pt_checker
// Port-level checks of the translator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sv39pt_checker import sv39pt_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic [FUNC_W-1:0]   req_func,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [PADDR_W-1:0]  rsp_paddr,
  input logic [STATUS_W-1:0] rsp_status
);

  // response stays put while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_paddr) && $stable(rsp_status))
    else $error("response changed while stalled");

  a_paddr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != STATUS_OK) |-> rsp_paddr == '0)
    else $error("nonzero paddr on failed translation");

  a_page_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_paddr[PAGE_SHIFT-1:0] == '0)
    else $error("paddr not page aligned");

  // a write with a free output answers at once with zero
  a_write_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_func == FUNC_WRITE) && (!rsp_valid || rsp_ready)
    |=> rsp_valid && (rsp_status == STATUS_OK) && (rsp_paddr == '0))
    else $error("write response wrong");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind sv39_page_table_translate sv39pt_checker u_sv39pt_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_func   (req.func),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_paddr  (rsp.paddr),
  .rsp_status (rsp.status)
);

`default_nettype wire

@@ tb/sv39pt_walk_monitor.sv @@
// ----------------------------------------------------------------------------
// sv39pt_walk_monitor
// Watches the request, response and root-page channels of the Sv39
// translator. It keeps a shadow copy of the page-table store and of the root
// page, works out the response of every accepted request word with its own
// three-level walk, and compares each response word field by field against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sv39pt_walk_monitor import sv39pt_pkg::*; #(
  parameter int TABLE_PAGES   = 16,
  parameter int VA_LIMIT_BITS = 38
) (
  input  logic  clk,
  input  logic  rst,
  sv39pt_req_if req,
  sv39pt_rsp_if rsp,
  sv39pt_cfg_if cfg,
  output int    errors,
  output int    pending,
  output int    walks_ok
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_WORDS = TABLE_PAGES * PAGE_WORDS;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [PADDR_W-1:0] paddr;
    status_t            status;
  } xlate_result_t;

  logic [WORD_W-1:0] table_shadow [STORE_WORDS];
  logic [ROOT_W-1:0] root_shadow;
  xlate_result_t     expected_results [$];
  int                err_total = 0;
  int                ok_total  = 0;

  function automatic xlate_result_t predict_walk(logic [VADDR_W-1:0] va);
    xlate_result_t    res;
    logic [WORD_W-1:0] pte;
    logic [PPN_W-1:0]  page;
    int                lvl;
    res.paddr  = '0;
    res.status = STATUS_OK;
    if ((va >> VA_LIMIT_BITS) != 0) begin
      res.status = STATUS_LIMIT;
      return res;
    end
    page = PPN_W'(root_shadow);
    if (page >= TABLE_PAGES) begin
      res.status = STATUS_OUTSIDE;
      return res;
    end
    // upper levels: any valid entry is a pointer, permissions ignored
    for (lvl = 2; lvl > 0; lvl--) begin
      pte = table_shadow[int'(page) * PAGE_WORDS + int'(va[PAGE_SHIFT + VPN_W * lvl +: VPN_W])];
      if (!pte[PTE_V_BIT]) begin
        res.status = STATUS_MISSING;
        return res;
      end
      page = pte[PPN_LSB +: PPN_W];
      if (page >= TABLE_PAGES) begin
        res.status = STATUS_OUTSIDE;
        return res;
      end
    end
    pte = table_shadow[int'(page) * PAGE_WORDS + int'(va[PAGE_SHIFT +: VPN_W])];
    if (!pte[PTE_V_BIT]) begin
      res.status = STATUS_LEAF_INVALID;
      return res;
    end
    if (!pte[PTE_U_BIT]) begin
      res.status = STATUS_NOT_USER;
      return res;
    end
    res.paddr = PADDR_W'({pte[PPN_LSB +: PPN_W], {PAGE_SHIFT{1'b0}}});
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    if (err_total < MAX_PRINTED)
      $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_total++;
  endtask

  always @(posedge clk) begin
    xlate_result_t want;
    if (rst) begin
      foreach (table_shadow[i]) table_shadow[i] = '0;
      root_shadow = '0;
      expected_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) root_shadow = cfg.root_page;
      // pop before push: a response never belongs to the word taken at the same edge
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("response word with nothing outstanding", WORD_W'(rsp.paddr), '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp.paddr !== want.paddr)
            report_mismatch("paddr", WORD_W'(rsp.paddr), WORD_W'(want.paddr));
          if (rsp.status !== want.status)
            report_mismatch("status", WORD_W'(rsp.status), WORD_W'(want.status));
        end
      end
      if (req.valid && req.ready) begin
        if (req.func == FUNC_WRITE) begin
          if (req.entry_index < STORE_WORDS) table_shadow[req.entry_index] = req.entry_value;
          want.paddr  = '0;
          want.status = STATUS_OK;
        end else begin
          want = predict_walk(req.vaddr);
          if (want.status == STATUS_OK) ok_total++;
        end
        expected_results.push_back(want);
      end
    end
    errors   <= err_total;
    pending  <= expected_results.size();
    walks_ok <= ok_total;
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the Sv39 page-table translator. A directed part
// walks every status and the field extremes, then several root-page phases
// build random three-level table chains and translate through them, mixed
// with noise writes and stray addresses. Both sides idle at random and the
// response side holds off once for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module testbench import sv39pt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_PAGES    = 16;
  localparam int VA_BITS        = 38;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 210;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 30000;

  localparam logic [VADDR_W-1:0] TOP_VA = 64'h0000_003F_FFFF_FFFF;

  logic clk;
  logic rst;

  sv39pt_req_if req_ch ();
  sv39pt_rsp_if rsp_ch ();
  sv39pt_cfg_if cfg_ch ();

  int errors;
  int pending;
  int walks_ok;

  int words_sent  = 0;
  int n_writes    = 0;
  int n_xlates    = 0;
  int n_roots     = 0;
  int idle_cycles = 0;
  bit sender_fast = 0;
  logic [ROOT_W-1:0] root_now = '0;

  sv39_page_table_translate #(
    .TABLE_PAGES   (TABLE_PAGES),
    .VA_LIMIT_BITS (VA_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  sv39pt_walk_monitor #(
    .TABLE_PAGES   (TABLE_PAGES),
    .VA_LIMIT_BITS (VA_BITS)
  ) walk_mon (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg      (cfg_ch),
    .errors   (errors),
    .pending  (pending),
    .walks_ok (walks_ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no word moved for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [WORD_W-1:0] make_pte(logic [PPN_W-1:0] ppn, logic [9:0] low,
                                                 logic [9:0] rsvd);
    return {rsvd, ppn, low};
  endfunction

  function automatic logic [INDEX_W-1:0] table_slot(logic [ROOT_W-1:0] page,
                                                    logic [VADDR_W-1:0] va, int lvl);
    return {page, va[PAGE_SHIFT + VPN_W * lvl +: VPN_W]};
  endfunction

  // mostly a valid pointer into the store, now and then missing or far outside
  function automatic logic [WORD_W-1:0] pointer_pte(logic [ROOT_W-1:0] page);
    logic [PPN_W-1:0] ppn;
    logic [9:0]       low;
    ppn = PPN_W'(page);
    if ($urandom_range(0, 11) == 0) ppn = PPN_W'({$urandom, $urandom});
    else if ($urandom_range(0, 11) == 0) ppn = PPN_W'($urandom_range(16, 31));
    low = 10'($urandom);
    low[PTE_V_BIT] = ($urandom_range(0, 9) != 0);
    return make_pte(ppn, low, 10'($urandom));
  endfunction

  function automatic logic [WORD_W-1:0] leaf_pte();
    logic [9:0] low;
    low = 10'($urandom);
    low[PTE_V_BIT] = ($urandom_range(0, 6) != 0);
    low[PTE_U_BIT] = ($urandom_range(0, 6) != 0);
    return make_pte(PPN_W'({$urandom, $urandom}), low, 10'($urandom));
  endfunction

  task automatic send_word(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx,
                           logic [WORD_W-1:0] val, logic [VADDR_W-1:0] va);
    int gap;
    if (words_sent % 40 == 0) sender_fast = ($urandom_range(0, 3) == 0);
    gap = sender_fast ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= f;
    req_ch.entry_index <= idx;
    req_ch.entry_value <= val;
    req_ch.vaddr       <= va;
    do @(posedge clk); while (!req_ch.ready);
    words_sent++;
    if (f == FUNC_WRITE) n_writes++;
    else n_xlates++;
  endtask

  task automatic write_entry(logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] val);
    send_word(FUNC_WRITE, idx, val, {$urandom, $urandom});
  endtask

  task automatic translate_va(logic [VADDR_W-1:0] va);
    send_word(FUNC_XLATE, INDEX_W'($urandom), {$urandom, $urandom}, va);
  endtask

  // only while the block is idle: every response back, then a short settle
  task automatic set_root(logic [ROOT_W-1:0] r);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.root_page <= r;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    root_now = r;
    n_roots++;
  endtask

  initial begin : rsp_sink
    int gap;
    int taken;
    bit fast;
    rsp_ch.ready = 1'b0;
    taken = 0;
    fast  = 0;
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) fast = ($urandom_range(0, 3) == 0);
      gap = fast ? 0 : $urandom_range(0, 6);
      // one long hold-off so the block backs up and stalls its input
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      taken++;
    end
  end

  initial begin : stimulus
    logic [ROOT_W-1:0]  phase_root [PHASES];
    logic [ROOT_W-1:0]  p1;
    logic [ROOT_W-1:0]  p0;
    logic [VADDR_W-1:0] va;
    logic [VADDR_W-1:0] recent_va [$];
    int                 ph;
    int                 phase_end;
    int                 kind;

    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_WRITE;
    req_ch.entry_index = '0;
    req_ch.entry_value = '0;
    req_ch.vaddr       = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.root_page   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed walk through every status at root page 0
    translate_va('0);
    translate_va(64'h0000_0040_0000_0000);
    translate_va('1);
    translate_va(64'h8000_0000_0000_0000);
    write_entry(table_slot(4'd0, TOP_VA, 2), make_pte(PPN_W'(15), 10'h3FF, 10'h3FF));
    translate_va(TOP_VA);
    write_entry(table_slot(4'd15, TOP_VA, 1), make_pte(PPN_W'(1), 10'h001, 10'h000));
    translate_va(TOP_VA);
    write_entry(table_slot(4'd1, TOP_VA, 0), make_pte('1, 10'h3EF, 10'h3FF));
    translate_va(TOP_VA);
    write_entry(table_slot(4'd1, TOP_VA, 0), make_pte('1, 10'h3FF, 10'h3FF));
    translate_va(TOP_VA);
    write_entry(table_slot(4'd1, TOP_VA, 0), make_pte('0, 10'h010, 10'h000));
    translate_va(TOP_VA);
    write_entry(table_slot(4'd1, TOP_VA, 0), make_pte('0, 10'h011, 10'h000));
    translate_va(TOP_VA);
    write_entry(table_slot(4'd15, TOP_VA, 1), make_pte(PPN_W'(16), 10'h001, 10'h000));
    translate_va(TOP_VA);
    write_entry(table_slot(4'd0, TOP_VA, 2), make_pte('1, 10'h001, 10'h000));
    translate_va(TOP_VA);
    write_entry(table_slot(4'd0, TOP_VA, 2), make_pte(PPN_W'(15), 10'h3FE, 10'h3FF));
    translate_va(TOP_VA);
    write_entry('1, '1);
    write_entry('0, '0);

    phase_root[0] = 4'd15;
    phase_root[1] = 4'd0;
    phase_root[2] = ROOT_W'($urandom);
    phase_root[3] = 4'd9;
    phase_root[4] = ROOT_W'($urandom);
    phase_root[5] = 4'd15;

    for (ph = 0; ph < PHASES; ph++) begin
      set_root(phase_root[ph]);
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
          // build a chain root -> p1 -> p0 -> leaf, then walk it
          va = {$urandom, $urandom};
          va[VADDR_W-1:VA_BITS] = '0;
          p1 = ROOT_W'($urandom);
          p0 = ROOT_W'($urandom);
          if ($urandom_range(0, 4) != 0) write_entry(table_slot(root_now, va, 2), pointer_pte(p1));
          if ($urandom_range(0, 4) != 0) write_entry(table_slot(p1, va, 1), pointer_pte(p0));
          if ($urandom_range(0, 4) != 0) write_entry(table_slot(p0, va, 0), leaf_pte());
          translate_va(va);
          if ($urandom_range(0, 2) == 0) translate_va({va[VADDR_W-1:PAGE_SHIFT], 12'($urandom)});
          recent_va.push_back(va);
          if (recent_va.size() > 32) void'(recent_va.pop_front());
        end else if (kind == 6) begin
          case ($urandom_range(0, 2))
            0: translate_va({$urandom, $urandom});
            1: translate_va(VADDR_W'(1) << $urandom_range(VA_BITS, VADDR_W - 1));
            default: begin
              va = {$urandom, $urandom};
              va[VADDR_W-1:VA_BITS] = '0;
              translate_va(va);
            end
          endcase
        end else if (kind == 7) begin
          write_entry(INDEX_W'($urandom), {$urandom, $urandom});
        end else if (kind == 8 && recent_va.size() > 0) begin
          translate_va(recent_va[$urandom_range(0, recent_va.size() - 1)]);
        end else begin
          write_entry({root_now, VPN_W'($urandom)}, pointer_pte(ROOT_W'($urandom)));
        end
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d table writes and %0d translations, %0d mapped to a page",
             n_writes, n_xlates, walks_ok);
    $display("root page set %0d times, mismatches seen: %0d", n_roots, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
